/* design/afsk_nrzi_tone_modulator_defines.svh */
// Assertion helpers shared by the modulator RTL
`ifndef AFSK_NRZI_TONE_MODULATOR_DEFINES_SVH
`define AFSK_NRZI_TONE_MODULATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define AFSK_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afsk modulator check failed");

// Next-cycle implication, disabled while in reset
`define AFSK_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afsk modulator check failed");

`endif

/* design/afsk_ntm_pkg.sv */
package afsk_ntm_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MARK_STEP  = 2'd0,
        CFG_SPACE_STEP = 2'd1,
        CFG_SPB        = 2'd2,
        CFG_IDLE_LEVEL = 2'd3
    } cfg_idx_t;

    localparam int BUF_AW   = 8;   // packet buffer address bits (256 bytes)
    localparam int TBL_AW   = 9;   // sine table address bits (512 entries)
    localparam int PHASE_W  = 16;
    localparam int STEP_W   = 15;
    localparam int BLEN_W   = 11;
    localparam int BIDX_W   = 12;
    localparam int CFG_DW   = 15;

    // Phase is kept in hundredths of a table entry
    localparam logic [PHASE_W:0] PHASE_WRAP = 17'd51200;

    // floor(x/100) == (x*83887) >> 23 for every x below PHASE_WRAP
    localparam logic [16:0] RECIP_MULT  = 17'd83887;
    localparam int          RECIP_SHIFT = 23;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] MARK_STEP_RST  = 15'd2327;
    localparam logic [STEP_W-1:0] SPACE_STEP_RST = 15'd4267;
    localparam logic [7:0]        SPB_RST        = 8'd22;
    localparam logic [7:0]        IDLE_LEVEL_RST = 8'd128;

    // Packet buffer write request
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] sample;
        logic       busy;
        logic       done;
        logic       mark;
    } result_t;

    localparam logic [7:0] SINE_ROM [0:511] = '{
        8'd128,8'd129,8'd131,8'd132,8'd134,8'd135,8'd137,8'd138,
        8'd140,8'd142,8'd143,8'd145,8'd146,8'd148,8'd149,8'd151,
        8'd152,8'd154,8'd155,8'd157,8'd158,8'd160,8'd162,8'd163,
        8'd165,8'd166,8'd167,8'd169,8'd170,8'd172,8'd173,8'd175,
        8'd176,8'd178,8'd179,8'd181,8'd182,8'd183,8'd185,8'd186,
        8'd188,8'd189,8'd190,8'd192,8'd193,8'd194,8'd196,8'd197,
        8'd198,8'd200,8'd201,8'd202,8'd203,8'd205,8'd206,8'd207,
        8'd208,8'd210,8'd211,8'd212,8'd213,8'd214,8'd215,8'd217,
        8'd218,8'd219,8'd220,8'd221,8'd222,8'd223,8'd224,8'd225,
        8'd226,8'd227,8'd228,8'd229,8'd230,8'd231,8'd232,8'd233,
        8'd234,8'd234,8'd235,8'd236,8'd237,8'd238,8'd238,8'd239,
        8'd240,8'd241,8'd241,8'd242,8'd243,8'd243,8'd244,8'd245,
        8'd245,8'd246,8'd246,8'd247,8'd248,8'd248,8'd249,8'd249,
        8'd250,8'd250,8'd250,8'd251,8'd251,8'd252,8'd252,8'd252,
        8'd253,8'd253,8'd253,8'd253,8'd254,8'd254,8'd254,8'd254,
        8'd254,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
        8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
        8'd254,8'd254,8'd254,8'd254,8'd254,8'd253,8'd253,8'd253,
        8'd253,8'd252,8'd252,8'd252,8'd251,8'd251,8'd250,8'd250,
        8'd250,8'd249,8'd249,8'd248,8'd248,8'd247,8'd246,8'd246,
        8'd245,8'd245,8'd244,8'd243,8'd243,8'd242,8'd241,8'd241,
        8'd240,8'd239,8'd238,8'd238,8'd237,8'd236,8'd235,8'd234,
        8'd234,8'd233,8'd232,8'd231,8'd230,8'd229,8'd228,8'd227,
        8'd226,8'd225,8'd224,8'd223,8'd222,8'd221,8'd220,8'd219,
        8'd218,8'd217,8'd215,8'd214,8'd213,8'd212,8'd211,8'd210,
        8'd208,8'd207,8'd206,8'd205,8'd203,8'd202,8'd201,8'd200,
        8'd198,8'd197,8'd196,8'd194,8'd193,8'd192,8'd190,8'd189,
        8'd188,8'd186,8'd185,8'd183,8'd182,8'd181,8'd179,8'd178,
        8'd176,8'd175,8'd173,8'd172,8'd170,8'd169,8'd167,8'd166,
        8'd165,8'd163,8'd162,8'd160,8'd158,8'd157,8'd155,8'd154,
        8'd152,8'd151,8'd149,8'd148,8'd146,8'd145,8'd143,8'd142,
        8'd140,8'd138,8'd137,8'd135,8'd134,8'd132,8'd131,8'd129,
        8'd128,8'd126,8'd124,8'd123,8'd121,8'd120,8'd118,8'd117,
        8'd115,8'd113,8'd112,8'd110,8'd109,8'd107,8'd106,8'd104,
        8'd103,8'd101,8'd100,8'd98,8'd97,8'd95,8'd93,8'd92,
        8'd90,8'd89,8'd88,8'd86,8'd85,8'd83,8'd82,8'd80,
        8'd79,8'd77,8'd76,8'd74,8'd73,8'd72,8'd70,8'd69,
        8'd67,8'd66,8'd65,8'd63,8'd62,8'd61,8'd59,8'd58,
        8'd57,8'd55,8'd54,8'd53,8'd52,8'd50,8'd49,8'd48,
        8'd47,8'd45,8'd44,8'd43,8'd42,8'd41,8'd40,8'd38,
        8'd37,8'd36,8'd35,8'd34,8'd33,8'd32,8'd31,8'd30,
        8'd29,8'd28,8'd27,8'd26,8'd25,8'd24,8'd23,8'd22,
        8'd21,8'd21,8'd20,8'd19,8'd18,8'd17,8'd17,8'd16,
        8'd15,8'd14,8'd14,8'd13,8'd12,8'd12,8'd11,8'd10,
        8'd10,8'd9,8'd9,8'd8,8'd7,8'd7,8'd6,8'd6,
        8'd5,8'd5,8'd5,8'd4,8'd4,8'd3,8'd3,8'd3,
        8'd2,8'd2,8'd2,8'd2,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,
        8'd2,8'd3,8'd3,8'd3,8'd4,8'd4,8'd5,8'd5,
        8'd5,8'd6,8'd6,8'd7,8'd7,8'd8,8'd9,8'd9,
        8'd10,8'd10,8'd11,8'd12,8'd12,8'd13,8'd14,8'd14,
        8'd15,8'd16,8'd17,8'd17,8'd18,8'd19,8'd20,8'd21,
        8'd21,8'd22,8'd23,8'd24,8'd25,8'd26,8'd27,8'd28,
        8'd29,8'd30,8'd31,8'd32,8'd33,8'd34,8'd35,8'd36,
        8'd37,8'd38,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,
        8'd47,8'd48,8'd49,8'd50,8'd52,8'd53,8'd54,8'd55,
        8'd57,8'd58,8'd59,8'd61,8'd62,8'd63,8'd65,8'd66,
        8'd67,8'd69,8'd70,8'd72,8'd73,8'd74,8'd76,8'd77,
        8'd79,8'd80,8'd82,8'd83,8'd85,8'd86,8'd88,8'd89,
        8'd90,8'd92,8'd93,8'd95,8'd97,8'd98,8'd100,8'd101,
        8'd103,8'd104,8'd106,8'd107,8'd109,8'd110,8'd112,8'd113,
        8'd115,8'd117,8'd118,8'd120,8'd121,8'd123,8'd124,8'd126
    };

endpackage

/* design/afsk_ntm_store.sv */
// Packet buffer: one write port, one registered read port with write forwarding,
// plus a register copy of byte 0 so a start can load it without a read.
module afsk_ntm_store
(
    input  logic                              clk,
    input  afsk_ntm_pkg::store_wr_t           wr,
    input  logic [afsk_ntm_pkg::BUF_AW-1:0]   rd_addr,
    output logic [7:0]                        rd_data,
    output logic [7:0]                        byte0
);

    logic [7:0] mem [0:(1 << afsk_ntm_pkg::BUF_AW)-1];
    logic [7:0] rd_data_reg;
    logic [7:0] byte0_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port; a same-cycle write to the read address is passed through
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Shadow of byte 0
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == '0))
        begin
            byte0_reg <= wr.data;
        end
    end

    assign rd_data = rd_data_reg;
    assign byte0   = byte0_reg;

endmodule

/* design/afsk_ntm_core.sv */
`include "afsk_nrzi_tone_modulator_defines.svh"

// Modulator state: configuration registers, phase accumulator, bit timing,
// NRZI tone select. Computes the result of the accepted transaction.
module afsk_ntm_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [afsk_ntm_pkg::CFG_DW-1:0]     cfg_data,
    // accepted transaction
    input  logic                                fire,
    input  logic [1:0]                          op,
    input  logic [afsk_ntm_pkg::BUF_AW-1:0]     byte_addr,
    input  logic [7:0]                          byte_data,
    input  logic [afsk_ntm_pkg::BLEN_W-1:0]     bit_length,
    // packet buffer
    output afsk_ntm_pkg::store_wr_t             store_wr,
    output logic [afsk_ntm_pkg::BUF_AW-1:0]     store_rd_addr,
    input  logic [7:0]                          store_rd_data,
    input  logic [7:0]                          store_byte0,
    // result of this transaction
    output afsk_ntm_pkg::result_t               res
);

    localparam int PW = afsk_ntm_pkg::PHASE_W;
    localparam int SW = afsk_ntm_pkg::STEP_W;
    localparam int LW = afsk_ntm_pkg::BLEN_W;
    localparam int BW = afsk_ntm_pkg::BIDX_W;

    logic [SW-1:0] mark_step_reg;
    logic [SW-1:0] space_step_reg;
    logic [7:0]    spb_reg;
    logic [7:0]    idle_reg;

    logic [PW-1:0] phase_reg,  phase_next;
    logic          mark_reg,   mark_next;
    logic [7:0]    tick_reg,   tick_next;
    logic [BW-1:0] bidx_reg,   bidx_next;
    logic [LW-1:0] len_reg,    len_next;
    logic [7:0]    shift_reg,  shift_next;
    logic          active_reg, active_next;

    logic [7:0]    sample_next;
    logic          done_next;

    logic [32:0]   quot_prod;
    logic [afsk_ntm_pkg::TBL_AW-1:0] tbl_idx;
    logic [SW-1:0] step_sel;
    logic [PW:0]   phase_sum;
    logic [PW:0]   phase_wrapped;
    logic [7:0]    tick_inc;
    logic [BW-1:0] bidx_inc;
    logic [7:0]    shift_new;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_step_reg  <= afsk_ntm_pkg::MARK_STEP_RST;
            space_step_reg <= afsk_ntm_pkg::SPACE_STEP_RST;
            spb_reg        <= afsk_ntm_pkg::SPB_RST;
            idle_reg       <= afsk_ntm_pkg::IDLE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (afsk_ntm_pkg::cfg_idx_t'(cfg_index))
                afsk_ntm_pkg::CFG_MARK_STEP:  mark_step_reg  <= cfg_data[SW-1:0];
                afsk_ntm_pkg::CFG_SPACE_STEP: space_step_reg <= cfg_data[SW-1:0];
                afsk_ntm_pkg::CFG_SPB:        spb_reg        <= cfg_data[7:0];
                afsk_ntm_pkg::CFG_IDLE_LEVEL: idle_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Table index = phase / 100 through a reciprocal multiply
    assign quot_prod = 33'(phase_reg) * 33'(afsk_ntm_pkg::RECIP_MULT);
    assign tbl_idx   = quot_prod[afsk_ntm_pkg::RECIP_SHIFT +: afsk_ntm_pkg::TBL_AW];

    // Phase advance with a single wrap
    assign step_sel      = mark_reg ? mark_step_reg : space_step_reg;
    assign phase_sum     = (PW + 1)'(phase_reg) + (PW + 1)'(step_sel);
    assign phase_wrapped = (phase_sum >= afsk_ntm_pkg::PHASE_WRAP)
                         ? phase_sum - afsk_ntm_pkg::PHASE_WRAP : phase_sum;

    assign tick_inc = tick_reg + 8'd1;
    assign bidx_inc = bidx_reg + BW'(1);

    // Next byte to load is always the one after the current bit's byte
    assign store_rd_addr = bidx_reg[3 +: afsk_ntm_pkg::BUF_AW] + afsk_ntm_pkg::BUF_AW'(1);
    assign shift_new     = (bidx_inc[2:0] == 3'd0) ? store_rd_data : (shift_reg >> 1);

    // Packet buffer write
    always_comb
    begin
        store_wr.en   = fire && (op == afsk_ntm_pkg::OP_WRITE);
        store_wr.addr = byte_addr;
        store_wr.data = byte_data;
    end

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        mark_next   = mark_reg;
        tick_next   = tick_reg;
        bidx_next   = bidx_reg;
        len_next    = len_reg;
        shift_next  = shift_reg;
        active_next = active_reg;
        sample_next = idle_reg;
        done_next   = 1'b0;

        if (fire)
        begin
            unique case (afsk_ntm_pkg::op_t'(op))
                afsk_ntm_pkg::OP_WRITE: ;
                afsk_ntm_pkg::OP_START:
                begin
                    if (bit_length != '0)
                    begin
                        tick_next   = '0;
                        bidx_next   = '0;
                        phase_next  = '0;
                        mark_next   = 1'b0;
                        len_next    = bit_length;
                        shift_next  = store_byte0;
                        active_next = 1'b1;
                    end
                end
                afsk_ntm_pkg::OP_TICK:
                begin
                    if (active_reg)
                    begin
                        sample_next = afsk_ntm_pkg::SINE_ROM[tbl_idx];
                        phase_next  = phase_wrapped[PW-1:0];
                        tick_next   = tick_inc;
                        if (tick_inc == spb_reg)
                        begin
                            tick_next = '0;
                            bidx_next = bidx_inc;
                            if (bidx_inc > BW'(len_reg))
                            begin
                                // end of packet
                                active_next = 1'b0;
                                len_next    = '0;
                                done_next   = 1'b1;
                                sample_next = idle_reg;
                            end
                            else
                            begin
                                // NRZI: a zero bit flips the tone
                                shift_next = shift_new;
                                if (!shift_new[0])
                                begin
                                    mark_next = !mark_reg;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            mark_reg   <= 1'b0;
            tick_reg   <= '0;
            bidx_reg   <= '0;
            len_reg    <= '0;
            shift_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            mark_reg   <= mark_next;
            tick_reg   <= tick_next;
            bidx_reg   <= bidx_next;
            len_reg    <= len_next;
            shift_reg  <= shift_next;
            active_reg <= active_next;
        end
    end

    always_comb
    begin
        res.sample = sample_next;
        res.busy   = active_next;
        res.done   = done_next;
        res.mark   = mark_next;
    end

    // Checks
    `AFSK_AST_IMP(a_phase_range, clk, rst_n, 1'b1, (17'(phase_reg) < afsk_ntm_pkg::PHASE_WRAP))
    `AFSK_AST_IMP(a_active_len, clk, rst_n, 1'b1, (active_reg == (len_reg != '0)))
    `AFSK_AST_IMP(a_bidx_bound, clk, rst_n, active_reg, (bidx_reg <= BW'(len_reg)))
    `AFSK_AST_NXT(a_done_stops, clk, rst_n, (fire && done_next), (!active_reg))

endmodule

/* design/afsk_ntm_obuf.sv */
`include "afsk_nrzi_tone_modulator_defines.svh"

// Two-entry result buffer: takes a new result while an older one still waits.
module afsk_ntm_obuf
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  afsk_ntm_pkg::result_t   push_data,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output afsk_ntm_pkg::result_t   out_data
);

    afsk_ntm_pkg::result_t slot0_reg, slot0_next;
    afsk_ntm_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]            cnt_reg,   cnt_next;
    logic                  pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;

    // Slot movement
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Checks
    `AFSK_AST_IMP(a_cnt_range, clk, rst_n, 1'b1, (cnt_reg != 2'd3))
    `AFSK_AST_NXT(a_push_empty, clk, rst_n, (push && cnt_reg == 2'd0), (out_data == $past(push_data)))

endmodule

/* design/afsk_nrzi_tone_modulator.sv */
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  s_tuser: op; s_tdata: byte_addr, byte_data, bit_length
// m_*       out  m_tvalid/m_tready  m_tdata: sample, busy_res, tone_is_mark; m_tlast: done_res
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One transaction per cycle while s_tready is high; each gives one result, registered in the result buffer.
// The path phase register -> reciprocal multiply -> sine table sets the cycle time.
// Reset (rst_n low) restores the register defaults and stops transmission; the
// packet buffer is not cleared and holds garbage until written.
// A two-entry result buffer keeps s_tready high while one result waits on m_tready.
module afsk_nrzi_tone_modulator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] byte_addr, [15:8] byte_data, [26:16] bit_length
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] sample, [8] busy_res, [9] tone_is_mark
    output logic        m_tlast,   // done_res
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [afsk_ntm_pkg::CFG_DW-1:0] cfg_data
);

    logic                                fire;
    afsk_ntm_pkg::store_wr_t             store_wr;
    logic [afsk_ntm_pkg::BUF_AW-1:0]     store_rd_addr;
    logic [7:0]                          store_rd_data;
    logic [7:0]                          store_byte0;
    afsk_ntm_pkg::result_t               res;
    afsk_ntm_pkg::result_t               out_res;

    assign fire = s_tvalid && s_tready;

    afsk_ntm_store u_store
    (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data),
        .byte0   (store_byte0)
    );

    afsk_ntm_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fire          (fire),
        .op            (s_tuser),
        .byte_addr     (s_tdata[7:0]),
        .byte_data     (s_tdata[15:8]),
        .bit_length    (s_tdata[26:16]),
        .store_wr      (store_wr),
        .store_rd_addr (store_rd_addr),
        .store_rd_data (store_rd_data),
        .store_byte0   (store_byte0),
        .res           (res)
    );

    afsk_ntm_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Output packing
    assign m_tdata = {6'd0, out_res.mark, out_res.busy, out_res.sample};
    assign m_tlast = out_res.done;

endmodule
